// File: rtl/sha1sh_pkg.sv
// ============================================================================
// sha1sh_pkg
// Shared types, constants and round functions of the SHA-1 stream hasher.
// ============================================================================
package sha1sh_pkg;

    typedef struct packed {
        logic       finish;
        logic [7:0] data;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } state_t;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hefcdab89;
    localparam logic [31:0] H2_INIT = 32'h98badcfe;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hc3d2e1f0;

    localparam logic [31:0] K_00_19 = 32'h5A827999;
    localparam logic [31:0] K_20_39 = 32'h6ED9EBA1;
    localparam logic [31:0] K_40_59 = 32'h8F1BBCDC;
    localparam logic [31:0] K_60_79 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_MARK    = 8'h80;
    localparam logic [5:0] LEN_POS     = 6'd56;
    localparam logic [5:0] LAST_POS    = 6'd63;
    localparam logic [6:0] LAST_ROUND  = 7'd79;
    localparam logic [2:0] LAST_WORD   = 3'd4;
    localparam logic [63:0] BYTE_BITS  = 64'd8;

    function automatic logic [31:0] round_k(input logic [6:0] r);
        logic [31:0] k;
        if (r < 7'd20) begin
            k = K_00_19;
        end else if (r < 7'd40) begin
            k = K_20_39;
        end else if (r < 7'd60) begin
            k = K_40_59;
        end else begin
            k = K_60_79;
        end
        return k;
    endfunction

    function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (r < 7'd20) begin
            f = (b & c) | (~b & d);
        end else if (r >= 7'd40 && r < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

endpackage

// File: rtl/sha1sh_front.sv
// ============================================================================
// sha1sh_front
// Input side: accepts items, tags finish versus data, and queues them.
// ============================================================================
module sha1sh_front #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_op,
    input  logic [7:0]        s_data_byte,
    output logic              q_valid,
    input  logic              q_ready,
    output sha1sh_pkg::item_t q_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    sha1sh_pkg::item_t       slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic                    push, pop;
    sha1sh_pkg::item_t       in_item;

    assign s_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        in_item.finish = s_op;
        in_item.data   = s_data_byte;
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: rtl/sha1sh_core.sv
// ============================================================================
// sha1sh_core
// Back end: byte packing, padding, 80-round compression and digest output.
// ============================================================================
module sha1sh_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  sha1sh_pkg::item_t q_item,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [31:0]       m_digest_word,
    output logic [2:0]        m_word_index,
    output logic              m_last
);

    sha1sh_pkg::state_t state_reg, state_next;

    logic [31:0] window_reg [16];
    logic [31:0] window_next [16];
    logic [31:0] hash_reg [5];
    logic [31:0] hash_next [5];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] a_next, b_next, c_next, d_next, e_next;
    logic [5:0]  pos_reg, pos_next;
    logic [63:0] bitlen_reg, bitlen_next;
    logic [6:0]  round_reg, round_next;
    logic [2:0]  widx_reg, widx_next;
    logic        pad_reg, pad_next;
    logic        mark_reg, mark_next;
    logic        len_phase_reg, len_phase_next;
    logic        final_reg, final_next;

    logic        put_en;
    logic [7:0]  put_byte;
    logic        len_sel;
    logic [5:0]  len_shift;
    logic [31:0] sched_word;
    logic [31:0] round_sum;

    assign q_ready = (state_reg == sha1sh_pkg::ST_IDLE);

    // byte k of the length goes at position 56 + k, most significant first
    assign len_sel   = !mark_reg && (len_phase_reg || pos_reg == sha1sh_pkg::LEN_POS);
    assign len_shift = {~pos_reg[2:0], 3'b000};

    assign sched_word = window_reg[13] ^ window_reg[8] ^ window_reg[2] ^ window_reg[0];
    assign round_sum  = {a_reg[26:0], a_reg[31:27]}
                      + sha1sh_pkg::round_f(round_reg, b_reg, c_reg, d_reg)
                      + e_reg + sha1sh_pkg::round_k(round_reg) + window_reg[0];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sha1sh_pkg::ST_IDLE: begin
                if (q_valid) begin
                    if (q_item.finish) begin
                        state_next = sha1sh_pkg::ST_PAD;
                    end else if (pos_reg == sha1sh_pkg::LAST_POS) begin
                        state_next = sha1sh_pkg::ST_ROUND;
                    end
                end
            end
            sha1sh_pkg::ST_PAD: begin
                if (pos_reg == sha1sh_pkg::LAST_POS) begin
                    state_next = sha1sh_pkg::ST_ROUND;
                end
            end
            sha1sh_pkg::ST_ROUND: begin
                if (round_reg == sha1sh_pkg::LAST_ROUND) begin
                    state_next = sha1sh_pkg::ST_ADD;
                end
            end
            sha1sh_pkg::ST_ADD: begin
                if (final_reg) begin
                    state_next = sha1sh_pkg::ST_EMIT;
                end else if (pad_reg) begin
                    state_next = sha1sh_pkg::ST_PAD;
                end else begin
                    state_next = sha1sh_pkg::ST_IDLE;
                end
            end
            sha1sh_pkg::ST_EMIT: begin
                if (m_ready && widx_reg == sha1sh_pkg::LAST_WORD) begin
                    state_next = sha1sh_pkg::ST_IDLE;
                end
            end
            default: state_next = sha1sh_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        put_en         = 1'b0;
        put_byte       = '0;
        pos_next       = pos_reg;
        bitlen_next    = bitlen_reg;
        round_next     = round_reg;
        widx_next      = widx_reg;
        pad_next       = pad_reg;
        mark_next      = mark_reg;
        len_phase_next = len_phase_reg;
        final_next     = final_reg;
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        e_next = e_reg;
        for (int i = 0; i < 5; i++) begin
            hash_next[i] = hash_reg[i];
        end
        for (int i = 0; i < 16; i++) begin
            window_next[i] = window_reg[i];
        end

        m_valid       = 1'b0;
        m_digest_word = hash_reg[widx_reg];
        m_word_index  = widx_reg;
        m_last        = (widx_reg == sha1sh_pkg::LAST_WORD);

        unique case (state_reg)
            sha1sh_pkg::ST_IDLE: begin
                if (q_valid) begin
                    if (q_item.finish) begin
                        pad_next  = 1'b1;
                        mark_next = 1'b1;
                    end else begin
                        put_en      = 1'b1;
                        put_byte    = q_item.data;
                        bitlen_next = bitlen_reg + sha1sh_pkg::BYTE_BITS;
                    end
                end
            end
            sha1sh_pkg::ST_PAD: begin
                put_en = 1'b1;
                if (mark_reg) begin
                    put_byte  = sha1sh_pkg::PAD_MARK;
                    mark_next = 1'b0;
                end else if (len_sel) begin
                    put_byte       = bitlen_reg[len_shift +: 8];
                    len_phase_next = 1'b1;
                    if (pos_reg == sha1sh_pkg::LAST_POS) begin
                        final_next = 1'b1;
                    end
                end
            end
            sha1sh_pkg::ST_ROUND: begin
                a_next     = round_sum;
                b_next     = a_reg;
                c_next     = {b_reg[1:0], b_reg[31:2]};
                d_next     = c_reg;
                e_next     = d_reg;
                round_next = round_reg + 7'd1;
                for (int i = 0; i < 15; i++) begin
                    window_next[i] = window_reg[i + 1];
                end
                window_next[15] = {sched_word[30:0], sched_word[31]};
            end
            sha1sh_pkg::ST_ADD: begin
                hash_next[0] = hash_reg[0] + a_reg;
                hash_next[1] = hash_reg[1] + b_reg;
                hash_next[2] = hash_reg[2] + c_reg;
                hash_next[3] = hash_reg[3] + d_reg;
                hash_next[4] = hash_reg[4] + e_reg;
            end
            sha1sh_pkg::ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    widx_next = widx_reg + 3'd1;
                    if (widx_reg == sha1sh_pkg::LAST_WORD) begin
                        // restart for the next message
                        widx_next      = '0;
                        bitlen_next    = '0;
                        pad_next       = 1'b0;
                        len_phase_next = 1'b0;
                        final_next     = 1'b0;
                        hash_next[0]   = sha1sh_pkg::H0_INIT;
                        hash_next[1]   = sha1sh_pkg::H1_INIT;
                        hash_next[2]   = sha1sh_pkg::H2_INIT;
                        hash_next[3]   = sha1sh_pkg::H3_INIT;
                        hash_next[4]   = sha1sh_pkg::H4_INIT;
                    end
                end
            end
            default: begin
            end
        endcase

        // shift the byte into the 512-bit block window, oldest byte on top
        if (put_en) begin
            for (int i = 0; i < 15; i++) begin
                window_next[i] = {window_reg[i][23:0], window_reg[i + 1][31:24]};
            end
            window_next[15] = {window_reg[15][23:0], put_byte};
            pos_next        = pos_reg + 6'd1;
            if (pos_reg == sha1sh_pkg::LAST_POS) begin
                round_next = '0;
                a_next     = hash_reg[0];
                b_next     = hash_reg[1];
                c_next     = hash_reg[2];
                d_next     = hash_reg[3];
                e_next     = hash_reg[4];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sha1sh_pkg::ST_IDLE;
            pos_reg       <= '0;
            bitlen_reg    <= '0;
            round_reg     <= '0;
            widx_reg      <= '0;
            pad_reg       <= 1'b0;
            mark_reg      <= 1'b0;
            len_phase_reg <= 1'b0;
            final_reg     <= 1'b0;
            hash_reg[0]   <= sha1sh_pkg::H0_INIT;
            hash_reg[1]   <= sha1sh_pkg::H1_INIT;
            hash_reg[2]   <= sha1sh_pkg::H2_INIT;
            hash_reg[3]   <= sha1sh_pkg::H3_INIT;
            hash_reg[4]   <= sha1sh_pkg::H4_INIT;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            bitlen_reg    <= bitlen_next;
            round_reg     <= round_next;
            widx_reg      <= widx_next;
            pad_reg       <= pad_next;
            mark_reg      <= mark_next;
            len_phase_reg <= len_phase_next;
            final_reg     <= final_next;
            for (int i = 0; i < 5; i++) begin
                hash_reg[i] <= hash_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        a_reg <= a_next;
        b_reg <= b_next;
        c_reg <= c_next;
        d_reg <= d_next;
        e_reg <= e_next;
        for (int i = 0; i < 16; i++) begin
            window_reg[i] <= window_next[i];
        end
    end

endmodule

// File: rtl/sha1_stream_hasher_unit.sv
// ============================================================================
// sha1_stream_hasher_unit
// SHA-1 over a byte stream: absorb bytes, then finish to get the digest.
// ============================================================================
// Usage: send items on the s_ channel (s_op = 0 absorbs s_data_byte,
// s_op = 1 ends the message). Each finish yields five m_ transfers, H0 to H4
// in order, with m_last on the fifth; the hasher then starts a new message.
// A queue of QUEUE_DEPTH items sits in front of the engine, so s_ready stays
// high while the engine compresses or waits on the receiver, until it fills.
// Throughput: the engine absorbs one byte per cycle, but each 64th byte starts
// a block: 80 rounds, one per cycle, then the chaining add, during which the
// engine takes no bytes. A single round unit does every round.
// After a finish, the engine writes the padding bytes (9 to 72) and compresses
// each block that padding completes (one or two), then gives the digest words
// at one per cycle while m_ready is high.
// When the receiver stalls, the current word holds and the engine waits;
// new input is queued until the queue is full.
// Reset (aresetn low, synchronous) loads the initial hash values, clears the
// byte position, the bit length and the queue; no clearing pass is needed.
// ============================================================================
module sha1_stream_hasher_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last
);

    logic              q_valid;
    logic              q_ready;
    sha1sh_pkg::item_t q_item;

    sha1sh_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_data_byte (s_data_byte),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item)
    );

    sha1sh_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .q_item        (q_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last        (m_last)
    );

endmodule

// File: tb/sv/tb_sha1_stream_hasher_unit.sv
// ============================================================================
// tb_sha1_stream_hasher_unit
// Self-checking bench for the SHA-1 stream hasher: short directed messages,
// some with known digests, then random messages, the first at a block or
// padding boundary, checked word by word against an in-bench SHA-1 predictor
// while both channels idle and stall in rotating phases.
// ============================================================================
module tb_sha1_stream_hasher_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 300;
    localparam int DIR_ROWS       = 14;
    localparam int RAND_MSGS      = 5;

    localparam logic [159:0] EMPTY_DIGEST = 160'hda39a3ee5e6b4b0d3255bfef95601890afd80709;
    localparam logic [159:0] ABC_DIGEST   = 160'ha9993e364706816aba3e25717850c26c9cd0d89d;

    typedef struct packed {
        logic         op;
        logic [7:0]   data;
        logic         known;
        logic [159:0] digest;
    } stim_row_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    logic        aclk;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic        s_op        = 1'b0;
    logic [7:0]  s_data_byte = 8'h00;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [31:0] m_digest_word;
    logic [2:0]  m_word_index;
    logic        m_last;

    sha1_stream_hasher_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_word (m_digest_word),
        .m_word_index  (m_word_index),
        .m_last        (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Predictor state
    logic [31:0] chain_words [5];
    logic [31:0] sched_words [16];
    logic [5:0]  fill_pos;
    logic [63:0] msg_bits;

    digest_beat_t digest_beats [$];
    digest_beat_t want_beat;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int err_count      = 0;
    int items_sent     = 0;
    int msgs_done      = 0;
    int beats_checked  = 0;
    int idle_cycles    = 0;

    stim_row_t dir_tbl [DIR_ROWS];

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void sha_restart();
        chain_words[0] = sha1sh_pkg::H0_INIT;
        chain_words[1] = sha1sh_pkg::H1_INIT;
        chain_words[2] = sha1sh_pkg::H2_INIT;
        chain_words[3] = sha1sh_pkg::H3_INIT;
        chain_words[4] = sha1sh_pkg::H4_INIT;
        fill_pos = '0;
        msg_bits = '0;
    endfunction

    function automatic void sha_compress();
        logic [31:0] a, b, c, d, e, f, w, t;
        int r;
        a = chain_words[0];
        b = chain_words[1];
        c = chain_words[2];
        d = chain_words[3];
        e = chain_words[4];
        for (r = 0; r < 80; r++) begin
            // expand the schedule in place over the 16-word window
            if (r >= 16) begin
                t = sched_words[(r + 13) % 16] ^ sched_words[(r + 8) % 16] ^
                    sched_words[(r + 2) % 16] ^ sched_words[r % 16];
                sched_words[r % 16] = rotl(t, 1);
            end
            w = sched_words[r % 16];
            if (r < 20) begin
                f = ((b & c) | (~b & d)) + sha1sh_pkg::K_00_19;
            end else if (r < 40) begin
                f = (b ^ c ^ d) + sha1sh_pkg::K_20_39;
            end else if (r < 60) begin
                f = ((b & c) | (b & d) | (c & d)) + sha1sh_pkg::K_40_59;
            end else begin
                f = (b ^ c ^ d) + sha1sh_pkg::K_60_79;
            end
            t = f + rotl(a, 5) + e + w;
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        chain_words[0] += a;
        chain_words[1] += b;
        chain_words[2] += c;
        chain_words[3] += d;
        chain_words[4] += e;
    endfunction

    function automatic void sha_put_byte(input logic [7:0] byte_in);
        sched_words[fill_pos[5:2]][8 * (3 - fill_pos[1:0]) +: 8] = byte_in;
        fill_pos = fill_pos + 6'd1;
        if (fill_pos == 6'd0) begin
            sha_compress();
        end
    endfunction

    // Returns 1 when the item closes a message; dig then holds H0..H4.
    function automatic bit sha_step(input logic op, input logic [7:0] data,
                                    output logic [159:0] dig);
        logic [63:0] len;
        int k;
        dig = '0;
        if (op == OP_ABSORB) begin
            msg_bits = msg_bits + 64'd8;
            sha_put_byte(data);
            return 1'b0;
        end
        len = msg_bits;
        sha_put_byte(sha1sh_pkg::PAD_MARK);
        while (fill_pos != sha1sh_pkg::LEN_POS) begin
            sha_put_byte(8'h00);
        end
        for (k = 7; k >= 0; k--) begin
            sha_put_byte(len[8 * k +: 8]);
        end
        dig = {chain_words[0], chain_words[1], chain_words[2], chain_words[3],
               chain_words[4]};
        sha_restart();
        return 1'b1;
    endfunction

    function automatic void set_phase(input int p);
        case (p % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
        endcase
    endfunction

    // Drive one item, hold it until the transfer, then predict its digest.
    task automatic send_item(input logic op, input logic [7:0] data, input logic known,
                             input logic [159:0] typed);
        logic [159:0] dig;
        digest_beat_t beat;
        int k;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_op        <= op;
        s_data_byte <= data;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (sha_step(op, data, dig)) begin
            msgs_done++;
            if (known) begin
                dig = typed;
            end
            for (k = 0; k < 5; k++) begin
                beat.word  = dig[159 - 32 * k -: 32];
                beat.index = 3'(k);
                beat.last  = (3'(k) == sha1sh_pkg::LAST_WORD);
                digest_beats.push_back(beat);
            end
        end
    endtask

    // Result channel: check each transfer, then pick next ready.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (digest_beats.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected digest transfer word=%h index=%0d last=%b",
                             $time, m_digest_word, m_word_index, m_last);
                end else begin
                    want_beat = digest_beats.pop_front();
                    beats_checked++;
                    if (m_digest_word !== want_beat.word) begin
                        err_count++;
                        $display("%0t: digest_word expected %h actual %h",
                                 $time, want_beat.word, m_digest_word);
                    end
                    if (m_word_index !== want_beat.index) begin
                        err_count++;
                        $display("%0t: word_index expected %0d actual %0d",
                                 $time, want_beat.index, m_word_index);
                    end
                    if (m_last !== want_beat.last) begin
                        err_count++;
                        $display("%0t: last expected %b actual %b",
                                 $time, want_beat.last, m_last);
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        int row;
        int m;
        int len;
        int b;
        int first_edge;
        int edge_lens [4];

        edge_lens = '{55, 56, 63, 64};
        dir_tbl = '{
            '{OP_FINISH, 8'h00, 1'b1, EMPTY_DIGEST},
            '{OP_ABSORB, 8'h61, 1'b0, 160'h0},
            '{OP_ABSORB, 8'h62, 1'b0, 160'h0},
            '{OP_ABSORB, 8'h63, 1'b0, 160'h0},
            '{OP_FINISH, 8'h00, 1'b1, ABC_DIGEST},
            '{OP_ABSORB, 8'h00, 1'b0, 160'h0},
            '{OP_FINISH, 8'h00, 1'b0, 160'h0},
            '{OP_ABSORB, 8'hff, 1'b0, 160'h0},
            '{OP_FINISH, 8'h00, 1'b0, 160'h0},
            // data byte on finish is ignored, back to back empty messages
            '{OP_FINISH, 8'hff, 1'b1, EMPTY_DIGEST},
            '{OP_FINISH, 8'h5a, 1'b1, EMPTY_DIGEST},
            '{OP_ABSORB, 8'h80, 1'b0, 160'h0},
            '{OP_ABSORB, 8'h7f, 1'b0, 160'h0},
            '{OP_FINISH, 8'ha5, 1'b0, 160'h0}
        };

        sha_restart();
        for (b = 0; b < 16; b++) begin
            sched_words[b] = '0;
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        set_phase(0);
        for (row = 0; row < DIR_ROWS; row++) begin
            send_item(dir_tbl[row].op, dir_tbl[row].data, dir_tbl[row].known,
                      dir_tbl[row].digest);
        end

        // Random messages: the first hits a padding boundary (fits one
        // block, spills into a second, or ends on a block-end absorb).
        first_edge = $urandom_range(3);
        for (m = 0; m < RAND_MSGS; m++) begin
            set_phase(m + 1);
            if (m == 0) begin
                len = edge_lens[first_edge];
            end else begin
                len = $urandom_range(12);
            end
            if ($urandom_range(7) == 0) begin
                send_item(OP_FINISH, 8'($urandom_range(255)), 1'b0, 160'h0);
            end
            for (b = 0; b < len; b++) begin
                send_item(OP_ABSORB, 8'($urandom_range(255)), 1'b0, 160'h0);
            end
            send_item(OP_FINISH, 8'($urandom_range(255)), 1'b0, 160'h0);
        end
        s_valid <= 1'b0;

        while (digest_beats.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d items in %0d messages, one of %0d bytes at a padding boundary.",
                 items_sent, msgs_done, edge_lens[first_edge]);
        $display("Checked %0d digest words across four idle/stall phases, %0d errors.",
                 beats_checked, err_count);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
